// ===== design/aec_pkg.sv =====
// Shared types, register indexes and constants for the echo comb block.
package aec_pkg;

    typedef logic signed [15:0] t_sample;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_GAIN     = 2'd2;

    localparam logic        ECHO_MODE_RST     = 1'b0;
    localparam logic [15:0] DELAY_SAMPLES_RST = 16'd44100;
    localparam logic [15:0] ECHO_GAIN_RST     = 16'd26214;

    localparam int DELAY_DEPTH_DEF = 65536;

    // Unity weight of the input sample in Q1.15
    localparam logic [16:0] GAIN_ONE = 17'd32768;

    // Quotient bits produced by the divider, one per step
    localparam int DIV_STEPS = 16;

    typedef struct packed {
        logic load_in;
        logic mem_rd;
        logic mac;
        logic abs_init;
        logic div_step;
        logic fix;
        logic mem_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic echo;
        logic out_free;
    } t_stat;

endpackage

// ===== design/aec_in_if.sv =====
// Input sample channel: valid/ready handshake with one PCM sample.
interface aec_in_if import aec_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

// ===== design/aec_out_if.sv =====
// Output sample channel: valid/ready handshake with one echoed PCM sample.
interface aec_out_if import aec_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample echo_sample;

    modport source (output valid, output echo_sample, input ready);
    modport sink (input valid, input echo_sample, output ready);
endinterface

// ===== design/audio_echo_comb_core.sv =====
// Echo comb filter top level: feedforward or feedback echo on a PCM sample stream.
//
// Usage:
//   i_in carries one signed 16-bit sample per transaction, o_out one echoed
//   sample per input, in order. Configuration (mode, delay, gain) is written
//   through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
//   Once the delay has filled, a sample passes through read, multiply-add,
//   magnitude, 16 divider steps, sign fix and write back to the output
//   register; while samples still pass through, the read goes straight to the
//   write back. A new sample is accepted in the cycle after the previous
//   one leaves for the output register, so no new sample is taken before the
//   last is through; the restoring divider makes one quotient bit per cycle.
//   The delay store is a single-port memory, one read and one write per
//   sample, DELAY_DEPTH entries (2 to 1048576); it needs no clearing.
//   Reset (synchronous, active low) loads the register defaults, zeroes the
//   write pointer and fill count, and empties the output register.
//   When the receiver stalls, the result waits in the output register and
//   the next sample is processed up to its write-back, then held there.
module audio_echo_comb_core import aec_pkg::*; #(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    aec_in_if.sink                i_in,
    aec_out_if.source             o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;

    aec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    aec_dp #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_in.sample_in),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_sample    (o_out.echo_sample),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

// ===== design/aec_ctrl.sv =====
// Sequencer per sample: read, echo multiply-add/divide, write back, output.
module aec_ctrl import aec_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_ABS   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIX   = 3'd5;
    localparam logic [2:0] S_WRITE = 3'd6;

    localparam int CW = $clog2(DIV_STEPS);
    localparam logic [CW-1:0] CNT_LAST = CW'(DIV_STEPS - 1);

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = i_stat.echo ? S_MAC : S_WRITE;
            end
            S_MAC: begin
                o_cmd.mac = 1'b1;
                n_state   = S_ABS;
            end
            S_ABS: begin
                o_cmd.abs_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_WRITE;
            end
            S_WRITE: begin
                if (i_stat.out_free) begin
                    o_cmd.mem_wr   = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef ASSERT_OFF
    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_READ))
        else $error("accepted transaction did not start a memory read");

    a_fix_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fix |-> $past(o_cmd.div_step))
        else $error("quotient fixed without a preceding divide step");

    a_div_full_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.abs_init |=> (o_cmd.div_step && r_cnt == '0))
        else $error("divider did not start from step zero");
`endif

endmodule

// ===== design/aec_dp.sv =====
// Datapath: config registers, delay memory, multiply-add, restoring divider, output register.
module aec_dp import aec_pkg::*; #(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_sample               i_sample,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_sample               o_sample,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int WW = ((AW > 16) ? AW : 16) + 1;

    // Configuration
    logic        r_mode;
    logic [15:0] r_delay;
    logic [15:0] r_gain;

    // Stream state
    logic [AW-1:0] r_wp;
    logic [15:0]   r_filled;

    // Per-sample working registers
    t_sample       r_x;
    t_sample       r_y;
    logic [AW-1:0] r_cur_wp;
    logic [AW-1:0] r_rd_addr;
    logic          r_echo;
    t_sample       r_rd_data;
    logic signed [32:0] r_num;
    logic          r_neg;
    logic [16:0]   r_den;
    logic [16:0]   r_rem;
    logic [15:0]   r_low;

    logic          r_out_valid;
    t_sample       r_out_data;

    t_sample       r_mem [DELAY_DEPTH];

    logic [WW-1:0] w_delay_ext;
    logic [WW-1:0] w_delay_max;
    logic [WW-1:0] w_d;
    logic [WW-1:0] w_wp_ext;
    logic [WW-1:0] w_rd_full;
    logic          w_echo;
    logic signed [32:0] w_prod;
    logic signed [32:0] w_xs;
    logic [32:0]   w_mag;
    logic [17:0]   w_trial;
    logic          w_ge;
    logic [AW-1:0] w_mem_addr;

    // Effective delay saturates below the store depth
    assign w_delay_ext = WW'(r_delay);
    assign w_delay_max = WW'(DELAY_DEPTH - 1);
    assign w_d         = (w_delay_ext > w_delay_max) ? w_delay_max : w_delay_ext;
    assign w_wp_ext    = WW'(r_wp);
    assign w_rd_full   = (w_wp_ext >= w_d) ? (w_wp_ext - w_d)
                                           : (w_wp_ext + WW'(DELAY_DEPTH) - w_d);
    assign w_echo      = (w_d != '0) && (WW'(r_filled) >= w_d);

    assign w_prod  = $signed({1'b0, r_gain}) * r_rd_data;
    assign w_xs    = {{2{r_x[15]}}, r_x, 15'd0};
    assign w_mag   = r_num[32] ? (33'd0 - r_num) : r_num;
    assign w_trial = {r_rem, r_low[15]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    assign w_mem_addr = i_cmd.mem_wr ? r_cur_wp : r_rd_addr;

    assign o_stat.echo     = r_echo;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_sample        = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ECHO_MODE_RST;
            r_delay  <= DELAY_SAMPLES_RST;
            r_gain   <= ECHO_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ECHO_MODE:     r_mode  <= i_cfg_data[0];
                CFG_DELAY_SAMPLES: r_delay <= i_cfg_data[15:0];
                CFG_ECHO_GAIN:     r_gain  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_filled <= '0;
        end else if (i_cmd.load_in) begin
            r_wp <= (r_wp == AW'(DELAY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (WW'(r_filled) < w_d) begin
                r_filled <= r_filled + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x       <= i_sample;
            r_y       <= i_sample;
            r_cur_wp  <= r_wp;
            r_rd_addr <= w_rd_full[AW-1:0];
            r_echo    <= w_echo;
        end
        if (i_cmd.mac) begin
            r_num <= w_xs + w_prod;
        end
        if (i_cmd.abs_init) begin
            // quotient fits 16 bits, so the top half is already below the divisor
            r_neg <= r_num[32];
            r_rem <= {1'b0, w_mag[31:16]};
            r_low <= w_mag[15:0];
            r_den <= GAIN_ONE + {1'b0, r_gain};
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? 17'(w_trial - {1'b0, r_den}) : w_trial[16:0];
            r_low <= {r_low[14:0], w_ge};
        end
        if (i_cmd.fix) begin
            r_y <= r_neg ? $signed(16'd0 - r_low) : $signed(r_low);
        end
    end

    // Single-port delay store
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[w_mem_addr] <= r_mode ? r_y : r_x;
        end else if (i_cmd.mem_rd) begin
            r_rd_data <= r_mem[w_mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_y;
        end
    end

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register loaded over an untaken transaction");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fix |-> (r_low <= 16'd32768))
        else $error("quotient magnitude out of sample range");

    a_addr_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mem_wr |-> (!r_echo || (r_cur_wp != r_rd_addr)))
        else $error("echo read and write address coincide");
`endif

endmodule
